FILE: hdl/r2f_pkg.sv
package r2f_pkg;

    localparam int NumW  = 63;
    localparam int MagW  = 64;
    localparam int BitsW = 64;
    localparam int StatW = 2;
    localparam int ExpW  = 12;
    localparam int QW    = 53;
    localparam int CntW  = 6;

    localparam logic [ExpW-1:0] DblBias = ExpW'(1023);
    localparam logic [ExpW-1:0] SglBias = ExpW'(127);

    localparam logic [CntW-1:0] DblLastBit = CntW'(53 - 1);
    localparam logic [CntW-1:0] SglLastBit = CntW'(24 - 1);

    localparam logic [MagW-1:0] DblLimit = (MagW'(1) << 62) - MagW'(1);
    localparam logic [MagW-1:0] SglLimit = (MagW'(1) << 31) - MagW'(1);

    localparam logic [StatW-1:0] StOk      = 2'd0;
    localparam logic [StatW-1:0] StZeroDen = 2'd1;
    localparam logic [StatW-1:0] StRange   = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic scale_d;
        logic scale_n;
        logic sub_first;
        logic div_step;
        logic pack;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic special;
        logic n_ge_2d;
        logic n_lt_d;
        logic div_last;
    } t_sts;

endpackage

FILE: hdl/r2f_in_if.sv
interface r2f_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [r2f_pkg::NumW-1:0] numerator;
    logic signed [r2f_pkg::NumW-1:0] denominator;
    logic                         double_precision;

    modport source (output valid, output numerator, output denominator,
                    output double_precision, input ready);
    modport sink   (input valid, input numerator, input denominator,
                    input double_precision, output ready);
endinterface

FILE: hdl/r2f_out_if.sv
interface r2f_out_if;
    logic                       valid;
    logic                       ready;
    logic [r2f_pkg::BitsW-1:0]  float_bits;
    logic [r2f_pkg::StatW-1:0]  status;

    modport source (output valid, output float_bits, output status, input ready);
    modport sink   (input valid, input float_bits, input status, output ready);
endinterface

FILE: hdl/rational_to_ieee_float.sv
// Signed rational to IEEE-754 converter.
//
// Input channel i_in carries a 63-bit signed numerator and denominator and a
// precision select (1: binary64, 0: binary32 in the low 32 bits). Output
// channel o_out carries the float bit pattern and a status code (ok, zero
// denominator, operand out of range). Both use valid/ready; a transaction
// moves when both are high.
//
// One item is worked at a time. After the input transaction the divisor
// or dividend is normalized, one shift per cycle, then the quotient is
// formed, one restoring-division bit per cycle through a single 65-bit
// subtractor, 53 bits for binary64 or 24 for binary32. Special cases (zero
// operand, out of range) go straight to packing. The next transaction is
// taken the cycle after the result is loaded.
//
// The result sits in an output register, so the next item is accepted
// while a result waits; if the receiver stalls, the following result waits
// in the datapath until the register frees. Reset (synchronous, active low)
// returns the controller to idle and drops any pending result.
module rational_to_ieee_float (
    input  logic       i_clk,
    input  logic       i_rst_n,
    r2f_in_if.sink     i_in,
    r2f_out_if.source  o_out
);

    r2f_pkg::t_cmd cmd;
    r2f_pkg::t_sts sts;

    // sequence the normalize, divide and pack steps
    r2f_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // magnitudes, shifter, divider, rounding and result register
    r2f_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_numerator        (i_in.numerator),
        .i_denominator      (i_in.denominator),
        .i_double_precision (i_in.double_precision),
        .o_float_bits       (o_out.float_bits),
        .o_status           (o_out.status)
    );

    // any error status carries a zero pattern
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != r2f_pkg::StOk) |-> (o_out.float_bits == '0))
        else $error("error result with nonzero float bits");

    // status code three is never produced
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == r2f_pkg::StOk) ||
                        (o_out.status == r2f_pkg::StZeroDen) ||
                        (o_out.status == r2f_pkg::StRange))
        else $error("undefined status code");

    // a taken transaction makes the block busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while busy");

endmodule

FILE: hdl/r2f_datapath.sv
module r2f_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  r2f_pkg::t_cmd                     i_cmd,
    output r2f_pkg::t_sts                     o_sts,
    input  logic signed [r2f_pkg::NumW-1:0]   i_numerator,
    input  logic signed [r2f_pkg::NumW-1:0]   i_denominator,
    input  logic                              i_double_precision,
    output logic [r2f_pkg::BitsW-1:0]         o_float_bits,
    output logic [r2f_pkg::StatW-1:0]         o_status
);

    logic [r2f_pkg::MagW-1:0]  r_n, n_n;
    logic [r2f_pkg::MagW-1:0]  r_d, n_d;
    logic [r2f_pkg::ExpW-1:0]  r_e, n_e;
    logic [r2f_pkg::QW-1:0]    r_q, n_q;
    logic [r2f_pkg::CntW-1:0]  r_cnt, n_cnt;
    logic                      r_neg, n_neg;
    logic                      r_dbl, n_dbl;
    logic                      r_zero, n_zero;
    logic [r2f_pkg::StatW-1:0] r_stat, n_stat;
    logic [r2f_pkg::BitsW-1:0] r_bits, n_bits;
    logic [r2f_pkg::StatW-1:0] r_ostat, n_ostat;

    logic [r2f_pkg::MagW-1:0]  num_sx, den_sx, num_mag, den_mag, limit;
    logic [r2f_pkg::MagW:0]    rem2, rem2_diff;
    logic                      rem_ge, out_of_range;
    logic [r2f_pkg::StatW-1:0] chk_stat;
    logic [r2f_pkg::QW-2:0]    qf;
    logic [r2f_pkg::QW-1:0]    q_sum;
    logic                      rnd_up, carry;
    logic [r2f_pkg::ExpW-1:0]  e_fin;
    logic [r2f_pkg::BitsW-1:0] packed_bits;

    // Operand magnitudes
    assign num_sx  = {i_numerator[r2f_pkg::NumW-1], i_numerator};
    assign den_sx  = {i_denominator[r2f_pkg::NumW-1], i_denominator};
    assign num_mag = i_numerator[r2f_pkg::NumW-1]   ? (r2f_pkg::MagW'(0) - num_sx) : num_sx;
    assign den_mag = i_denominator[r2f_pkg::NumW-1] ? (r2f_pkg::MagW'(0) - den_sx) : den_sx;

    // Range and zero checks on the registered magnitudes
    assign limit        = r_dbl ? r2f_pkg::DblLimit : r2f_pkg::SglLimit;
    assign out_of_range = (r_n > limit) || (r_d > limit);
    always_comb begin
        if (out_of_range) begin
            chk_stat = r2f_pkg::StRange;
        end else if (r_d == '0) begin
            chk_stat = r2f_pkg::StZeroDen;
        end else begin
            chk_stat = r2f_pkg::StOk;
        end
    end

    // One restoring division step
    assign rem2      = {r_n, 1'b0};
    assign rem2_diff = rem2 - {1'b0, r_d};
    assign rem_ge    = rem2 >= {1'b0, r_d};

    // Round to nearest even, carry into the exponent
    assign qf     = r_q[r2f_pkg::QW-1:1];
    assign rnd_up = r_q[0] && ((r_n != '0) || qf[0]);
    assign q_sum  = {1'b0, qf} + r2f_pkg::QW'(rnd_up);
    assign carry  = r_dbl ? q_sum[52] : q_sum[23];
    assign e_fin  = r_e + r2f_pkg::ExpW'(carry);

    always_comb begin
        if (r_zero) begin
            packed_bits = '0;
        end else if (r_dbl) begin
            packed_bits = {r_neg, e_fin[10:0], q_sum[51:0]};
        end else begin
            packed_bits = {32'd0, r_neg, e_fin[7:0], q_sum[22:0]};
        end
    end

    assign o_sts.special  = out_of_range || (r_d == '0) || (r_n == '0);
    assign o_sts.n_ge_2d  = {1'b0, r_n} >= {r_d, 1'b0};
    assign o_sts.n_lt_d   = r_n < r_d;
    assign o_sts.div_last = r_cnt == (r_dbl ? r2f_pkg::DblLastBit : r2f_pkg::SglLastBit);

    always_comb begin
        n_n     = r_n;
        n_d     = r_d;
        n_e     = r_e;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_dbl   = r_dbl;
        n_zero  = r_zero;
        n_stat  = r_stat;
        n_bits  = r_bits;
        n_ostat = r_ostat;
        if (i_cmd.load) begin
            n_n   = num_mag;
            n_d   = den_mag;
            n_neg = i_numerator[r2f_pkg::NumW-1] ^ i_denominator[r2f_pkg::NumW-1];
            n_dbl = i_double_precision;
            n_e   = i_double_precision ? r2f_pkg::DblBias : r2f_pkg::SglBias;
        end
        if (i_cmd.check) begin
            n_stat = chk_stat;
            n_zero = o_sts.special;
        end
        if (i_cmd.scale_d) begin
            n_d = {r_d[r2f_pkg::MagW-2:0], 1'b0};
            n_e = r_e + r2f_pkg::ExpW'(1);
        end
        if (i_cmd.scale_n) begin
            n_n = {r_n[r2f_pkg::MagW-2:0], 1'b0};
            n_e = r_e - r2f_pkg::ExpW'(1);
        end
        if (i_cmd.sub_first) begin
            n_n   = r_n - r_d;
            n_q   = '0;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_n   = rem_ge ? rem2_diff[r2f_pkg::MagW-1:0] : rem2[r2f_pkg::MagW-1:0];
            n_q   = {r_q[r2f_pkg::QW-2:0], rem_ge};
            n_cnt = r_cnt + r2f_pkg::CntW'(1);
        end
        if (i_cmd.pack) begin
            n_bits  = packed_bits;
            n_ostat = r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_n     <= n_n;
        r_d     <= n_d;
        r_e     <= n_e;
        r_q     <= n_q;
        r_neg   <= n_neg;
        r_dbl   <= n_dbl;
        r_zero  <= n_zero;
        r_stat  <= n_stat;
        r_bits  <= n_bits;
        r_ostat <= n_ostat;
    end

    assign o_float_bits = r_bits;
    assign o_status     = r_ostat;

    // the divisor must already be normalized against the dividend
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sub_first |-> (r_n >= r_d) && ({1'b0, r_n} < {r_d, 1'b0}))
        else $error("dividend not normalized at division start");

    // the partial remainder stays below the divisor
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_n < r_d))
        else $error("partial remainder not below divisor");

endmodule

FILE: hdl/r2f_ctrl.sv
module r2f_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  r2f_pkg::t_sts i_sts,
    output r2f_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCALE_D,
        S_SCALE_N,
        S_DIV,
        S_PACK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.special ? S_PACK : S_SCALE_D;
            end
            S_SCALE_D: begin
                if (i_sts.n_ge_2d) begin
                    o_cmd.scale_d = 1'b1;
                end else begin
                    n_state = S_SCALE_N;
                end
            end
            S_SCALE_N: begin
                if (i_sts.n_lt_d) begin
                    o_cmd.scale_n = 1'b1;
                end else begin
                    o_cmd.sub_first = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.pack  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sim/rational_to_ieee_float_test.sv
module rational_to_ieee_float_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit  = 1_000_000;
    localparam int DrainCycles = 130;   // longer than the longest conversion
    localparam int MaxReports  = 10;
    localparam int ResetCycles = 11;
    localparam int HoldCycles  = 600;

    // Floating-point formats, significand width including the hidden one
    localparam int DoublePrec = 53;
    localparam int SinglePrec = 24;
    localparam int DoubleExpW = 11;
    localparam int SingleExpW = 8;
    localparam int DoubleBias = 1023;
    localparam int SingleBias = 127;

    localparam longint MaxMag    = (longint'(1) << 62) - 1;
    localparam longint SingleMax = (longint'(1) << 31) - 1;

    // One conversion: the operands sent and the result they must produce
    typedef struct {
        logic [r2f_pkg::NumW-1:0]  numerator;
        logic [r2f_pkg::NumW-1:0]  denominator;
        logic                      double_precision;
        logic [r2f_pkg::BitsW-1:0] float_bits;
        logic [r2f_pkg::StatW-1:0] status;
    } t_conversion;

    logic clk = 1'b0;
    logic rst_n;

    r2f_in_if  conv_in ();
    r2f_out_if conv_out ();

    rational_to_ieee_float i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (conv_in),
        .o_out   (conv_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_conversion awaited_results[$];
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_cycles  = 0;  // long receiver hold-off, counted down by the sink
    int unsigned result_stall = 0;  // per-transaction receiver stall
    logic        no_idle      = 1'b0;

    // Hard stop: a hung handshake or a lost result ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("rational_to_ieee_float regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Expected behavior
    // ------------------------------------------------------------------

    function automatic logic [r2f_pkg::NumW-1:0] as_operand(longint value);
        return value[r2f_pkg::NumW-1:0];
    endfunction

    function automatic logic [r2f_pkg::MagW-1:0] operand_magnitude(
            logic [r2f_pkg::NumW-1:0] raw);
        logic [r2f_pkg::MagW-1:0] wide;
        wide = {raw[r2f_pkg::NumW-1], raw};
        return raw[r2f_pkg::NumW-1] ? -wide : wide;
    endfunction

    // n and d are nonzero magnitudes within range; returns the packed float
    function automatic logic [r2f_pkg::BitsW-1:0] encode_quotient(
            logic [r2f_pkg::MagW-1:0] n,
            logic [r2f_pkg::MagW-1:0] d,
            logic neg, logic dbl);
        int                       prec;
        int                       exp_w;
        int                       expo;
        logic [r2f_pkg::MagW-1:0] q;
        logic [r2f_pkg::MagW-1:0] frac_mask;
        logic                     round_bit;
        prec      = dbl ? DoublePrec : SinglePrec;
        exp_w     = dbl ? DoubleExpW : SingleExpW;
        expo      = dbl ? DoubleBias : SingleBias;
        q         = '0;
        frac_mask = (r2f_pkg::MagW'(1) << (prec - 1)) - r2f_pkg::MagW'(1);
        // Scale so that d <= n < 2d; each shift moves the exponent.
        while (n >= (d << 1)) begin
            d = d << 1;
            expo++;
        end
        while (n < d) begin
            n = n << 1;
            expo--;
        end
        n = n - d;
        // One quotient bit per step: fraction bits, then the round bit.
        for (int i = 0; i < prec; i++) begin
            n = n << 1;
            q = q << 1;
            if (n >= d) begin
                q[0] = 1'b1;
                n    = n - d;
            end
        end
        round_bit = q[0];
        q         = q >> 1;
        // Round to nearest, ties to even; a full carry bumps the exponent.
        if (round_bit && (n != '0 || q[0])) begin
            q = q + r2f_pkg::MagW'(1);
            if (q > frac_mask) begin
                q = '0;
                expo++;
            end
        end
        return (r2f_pkg::BitsW'(neg) << (prec - 1 + exp_w))
             | ((r2f_pkg::BitsW'(expo)
                 & ((r2f_pkg::BitsW'(1) << exp_w) - r2f_pkg::BitsW'(1))) << (prec - 1))
             | (q & frac_mask);
    endfunction

    function automatic t_conversion predict_conversion(logic [r2f_pkg::NumW-1:0] num,
                                                       logic [r2f_pkg::NumW-1:0] den,
                                                       logic dbl);
        t_conversion              r;
        logic [r2f_pkg::MagW-1:0] n_mag;
        logic [r2f_pkg::MagW-1:0] d_mag;
        logic [r2f_pkg::MagW-1:0] limit;
        r.numerator        = num;
        r.denominator      = den;
        r.double_precision = dbl;
        r.float_bits       = '0;
        r.status           = r2f_pkg::StOk;
        n_mag = operand_magnitude(num);
        d_mag = operand_magnitude(den);
        limit = dbl ? r2f_pkg::DblLimit : r2f_pkg::SglLimit;
        // Range wins over both zero cases; a zero numerator gives +0.
        if (n_mag > limit || d_mag > limit)
            r.status = r2f_pkg::StRange;
        else if (d_mag == '0)
            r.status = r2f_pkg::StZeroDen;
        else if (n_mag != '0)
            r.float_bits = encode_quotient(n_mag, d_mag,
                                           num[r2f_pkg::NumW-1] ^ den[r2f_pkg::NumW-1],
                                           dbl);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, and the check of each result
    // ------------------------------------------------------------------

    task automatic record_failure(string what);
        fail_count++;
        if (fail_count <= MaxReports)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // Drive ready at the falling edge; a long hold-off takes precedence.
    initial begin : result_ready_driver
        conv_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles != 0) begin
                conv_out.ready = 1'b0;
                hold_cycles--;
            end else if (result_stall != 0) begin
                conv_out.ready = 1'b0;
                result_stall--;
            end else begin
                conv_out.ready = 1'b1;
            end
        end
    end

    // Compare every result transaction with the oldest awaited conversion.
    always @(posedge clk) begin : result_check
        t_conversion want;
        if (rst_n && conv_out.valid && conv_out.ready) begin
            result_stall = no_idle ? 0 : $urandom_range(0, 10);
            if (awaited_results.size() == 0) begin
                record_failure($sformatf("unexpected result bits=%h status=%0d",
                                         conv_out.float_bits, conv_out.status));
            end else begin
                want = awaited_results.pop_front();
                if (conv_out.float_bits !== want.float_bits ||
                    conv_out.status !== want.status)
                    record_failure($sformatf(
                        "num=%0d den=%0d dbl=%0b: expected bits=%h status=%0d, got bits=%h status=%0d",
                        $signed(want.numerator), $signed(want.denominator),
                        want.double_precision, want.float_bits, want.status,
                        conv_out.float_bits, conv_out.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one conversion after a random gap; hold valid high once accepted
    // so that a back-to-back transaction needs no extra edge.
    task automatic send_conversion(input logic [r2f_pkg::NumW-1:0] num,
                                   input logic [r2f_pkg::NumW-1:0] den,
                                   input logic dbl);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap != 0) begin
            conv_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        conv_in.valid            = 1'b1;
        conv_in.numerator        = num;
        conv_in.denominator      = den;
        conv_in.double_precision = dbl;
        do @(posedge clk); while (!conv_in.ready);
        awaited_results.push_back(predict_conversion(num, den, dbl));
    endtask

    // Drop valid and wait until every awaited result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        conv_in.valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [r2f_pkg::NumW-1:0] signed_operand(
            logic [r2f_pkg::MagW-1:0] mag);
        return ($urandom_range(0, 1) == 1) ? r2f_pkg::NumW'(-mag) : r2f_pkg::NumW'(mag);
    endfunction

    // Random operand with a random exact bit length up to max_bits
    function automatic logic [r2f_pkg::NumW-1:0] random_operand(int unsigned max_bits);
        int unsigned              len;
        logic [r2f_pkg::MagW-1:0] mag;
        len = $urandom_range(0, max_bits);
        mag = {$urandom, $urandom} & ((r2f_pkg::MagW'(1) << len) - r2f_pkg::MagW'(1));
        if (len != 0)
            mag[len-1] = 1'b1;
        return signed_operand(mag);
    endfunction

    task automatic send_random_conversion();
        int unsigned              pick;
        int unsigned              width;
        int                       prec;
        logic                     dbl;
        logic [r2f_pkg::MagW-1:0] mag;
        logic [r2f_pkg::NumW-1:0] num;
        logic [r2f_pkg::NumW-1:0] den;
        logic [r2f_pkg::NumW-1:0] swap;
        dbl   = 1'($urandom_range(0, 1));
        width = dbl ? 62 : 31;
        prec  = dbl ? DoublePrec : SinglePrec;
        pick  = $urandom_range(0, 99);
        if (pick < 60) begin
            // ordinary operands of mixed lengths
            num = random_operand(width);
            den = random_operand(width);
        end else if (pick < 72) begin
            // one bit past the significand over a power of two: exact ties
            // when the last bit is zero below the round bit
            mag       = {$urandom, $urandom}
                      & ((r2f_pkg::MagW'(1) << (prec + 1)) - r2f_pkg::MagW'(1));
            mag[prec] = 1'b1;
            mag[0]    = ($urandom_range(0, 3) != 0);
            num = signed_operand(mag);
            den = signed_operand(r2f_pkg::MagW'(1) << $urandom_range(0, width - 1));
        end else if (pick < 80) begin
            // quotient close to one
            mag = ({$urandom, $urandom}
                   >> $urandom_range(r2f_pkg::MagW - width + 1, r2f_pkg::MagW - 1))
                | r2f_pkg::MagW'(1);
            den = signed_operand(mag);
            num = signed_operand(mag + r2f_pkg::MagW'($urandom_range(0, 2))
                                 - r2f_pkg::MagW'(1));
        end else if (pick < 88) begin
            // raw fields: every bit pattern, mostly out of range in single mode
            num = r2f_pkg::NumW'({$urandom, $urandom});
            den = r2f_pkg::NumW'({$urandom, $urandom});
        end else if (pick < 94) begin
            // just past the mode's range
            if (dbl)
                num = as_operand(-MaxMag - 1);
            else
                num = signed_operand((r2f_pkg::MagW'(1) << 31)
                                     + r2f_pkg::MagW'($urandom_range(0, 3)));
            den = random_operand(width);
            if ($urandom_range(0, 1) == 1) begin
                swap = num;
                num  = den;
                den  = swap;
            end
        end else begin
            // zero operands
            num = ($urandom_range(0, 1) == 1) ? '0 : random_operand(width);
            den = (num == '0 && $urandom_range(0, 1) == 1) ? random_operand(width) : '0;
        end
        send_conversion(num, den, dbl);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        // plain values and signs
        send_conversion(as_operand(1), as_operand(1), 1'b1);
        send_conversion(as_operand(-1), as_operand(1), 1'b1);
        send_conversion(as_operand(1), as_operand(3), 1'b1);
        send_conversion(as_operand(-1), as_operand(-3), 1'b0);
        // extreme magnitudes and exponents
        send_conversion(as_operand(MaxMag), as_operand(1), 1'b1);
        send_conversion(as_operand(1), as_operand(MaxMag), 1'b1);
        send_conversion(as_operand(-MaxMag), as_operand(MaxMag), 1'b1);
        send_conversion(as_operand(SingleMax), as_operand(1), 1'b0);
        send_conversion(as_operand(1), as_operand(-SingleMax), 1'b0);
        // operand out of range for the mode
        send_conversion(as_operand(-MaxMag - 1), as_operand(1), 1'b1);
        send_conversion(as_operand(1), as_operand(-MaxMag - 1), 1'b1);
        send_conversion(as_operand(SingleMax + 1), as_operand(1), 1'b0);
        send_conversion(as_operand(-SingleMax - 1), as_operand(3), 1'b0);
        send_conversion(as_operand(MaxMag), as_operand(7), 1'b0);
        // zeros; range takes priority over a zero denominator
        send_conversion(as_operand(0), as_operand(0), 1'b1);
        send_conversion(as_operand(5), as_operand(0), 1'b0);
        send_conversion(as_operand(-MaxMag - 1), as_operand(0), 1'b1);
        send_conversion(as_operand(0), as_operand(-7), 1'b1);
        send_conversion(as_operand(0), as_operand(9), 1'b0);
        // rounding: tie to even down, tie to even up, carry, sticky
        send_conversion(as_operand((longint'(1) << 24) + 1), as_operand(1), 1'b0);
        send_conversion(as_operand((longint'(1) << 24) + 3), as_operand(-1), 1'b0);
        send_conversion(as_operand((longint'(1) << 25) - 1), as_operand(1), 1'b0);
        send_conversion(as_operand(((longint'(1) << 24) + 1) * 4 + 1), as_operand(4), 1'b0);
        send_conversion(as_operand((longint'(1) << 53) + 1), as_operand(1), 1'b1);
        send_conversion(as_operand(-((longint'(1) << 53) + 3)), as_operand(1), 1'b1);
        send_conversion(as_operand((longint'(1) << 54) - 1), as_operand(-1), 1'b1);
    endtask

    // Random conversions in blocks; some blocks run with no idling at all.
    task automatic test_random_mix(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_random_conversion();
        end
        no_idle = 1'b0;
    endtask

    // Hold the receiver off for a long stretch while conversions keep
    // coming, so the output register and datapath fill and input stalls.
    task automatic test_output_backpressure();
        @(posedge clk);
        hold_cycles = HoldCycles;
        no_idle     = 1'b1;
        repeat (16) send_random_conversion();
        no_idle = 1'b0;
    endtask

    // Short bursts, each followed by a full drain before the next.
    task automatic test_drain_pauses();
        repeat (4) begin
            repeat (6) send_random_conversion();
            wait_for_results();
        end
    endtask

    initial begin
        rst_n                    = 1'b0;
        conv_in.valid            = 1'b0;
        conv_in.numerator        = '0;
        conv_in.denominator      = '0;
        conv_in.double_precision = 1'b0;
        repeat (ResetCycles) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        wait_for_results();
        test_random_mix(680);
        wait_for_results();
        test_output_backpressure();
        wait_for_results();
        test_drain_pauses();

        // Let any stray result show up before the verdict.
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0)
            $display("rational_to_ieee_float regression: pass");
        else
            $display("rational_to_ieee_float regression: fail");
        $finish;
    end

endmodule
